FILE: rtl/saext_pkg.sv
// Shared constants, types and helpers of the suffix automaton extender.
package saext_pkg;

   localparam int STATE_COUNT   = 4096;
   localparam int ALPHABET_SIZE = 26;
   localparam int STATE_W       = $clog2(STATE_COUNT);
   localparam int SYM_W         = 5;
   localparam int LEN_W         = STATE_W + 1;
   localparam int USED_W        = STATE_W + 1;
   localparam int COUNT_W       = 25;
   localparam int TR_DEPTH      = STATE_COUNT * ALPHABET_SIZE;
   localparam int TR_AW         = $clog2(TR_DEPTH);
   localparam int K_W           = $clog2(ALPHABET_SIZE);
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK_RD,
      ST_LOOK_CHK,
      ST_T_CHK,
      ST_FIND_RD,
      ST_FIND_CHK,
      ST_QLEN,
      ST_PLEN,
      ST_ALLOC,
      ST_ROW_CLR,
      ST_W2_RD,
      ST_W2_CHK,
      ST_LINK,
      ST_LINK_SET,
      ST_CLONE,
      ST_CP_RD,
      ST_CP_WR,
      ST_QLINK_RD,
      ST_QLINK_WR,
      ST_W3_RD,
      ST_W3_CHK,
      ST_FIX,
      ST_CURLINK,
      ST_COUNT,
      ST_BAD,
      ST_REFUSE,
      ST_HIT,
      ST_DONE
   } fsm_state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR_ROOT,
      OP_ACCEPT,
      OP_LOOK_RD,
      OP_LOOK_CHK,
      OP_WALK_RD,
      OP_FIND_CHK,
      OP_QLEN,
      OP_PLEN,
      OP_ALLOC,
      OP_ROW_CLR,
      OP_W2_CHK,
      OP_LINK_SET,
      OP_CLONE,
      OP_CP_RD,
      OP_CP_WR,
      OP_QLINK_RD,
      OP_QLINK_WR,
      OP_W3_CHK,
      OP_FIX,
      OP_CURLINK,
      OP_COUNT,
      OP_RES_BAD,
      OP_RES_FULL,
      OP_RES_T,
      OP_EMIT
   } op_type;

   typedef struct packed {
      logic sym_bad;
      logic tr_nz;
      logic tr_is_q;
      logic t_solid;
      logic p_zero;
      logic room1;
      logic refuse;
      logic clone_now;
      logic found;
      logic solid;
      logic clone;
      logic k_last;
      logic slot_free;
   } status_type;

   function automatic logic [TR_AW-1:0] tr_addr(input logic [STATE_W-1:0] s,
                                               input logic [SYM_W-1:0] c);
      logic [TR_AW-1:0] base;
      base = TR_AW'(s) * TR_AW'(ALPHABET_SIZE);
      return base + TR_AW'(c);
   endfunction

endpackage

FILE: rtl/saext_ifs.sv
// Valid/ready channel interfaces for request and response items.
interface saext_req_if;
   logic                         valid;
   logic                         ready;
   logic [saext_pkg::SYM_W-1:0]   symbol;
   logic [saext_pkg::STATE_W-1:0] from_state;
   modport source (output valid, output symbol, output from_state, input ready);
   modport sink   (input valid, input symbol, input from_state, output ready);
endinterface

interface saext_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [saext_pkg::STATE_W-1:0] next_state;
   logic [saext_pkg::COUNT_W-1:0] distinct_total;
   logic                         table_full;
   modport source (output valid, output next_state, output distinct_total,
                   output table_full, input ready);
   modport sink   (input valid, input next_state, input distinct_total,
                   input table_full, output ready);
endinterface

FILE: rtl/saext_ctrl.sv
// Sequencer that steps one item through lookup, link walks, allocation and cloning.
module saext_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  saext_pkg::status_type   status,
   output saext_pkg::op_type       op
);

   saext_pkg::fsm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= saext_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         saext_pkg::ST_CLEAR:    if (status.k_last) state_in = saext_pkg::ST_IDLE;
         saext_pkg::ST_IDLE:     if (req_valid) state_in = saext_pkg::ST_LOOK_RD;
         saext_pkg::ST_LOOK_RD:  state_in = status.sym_bad ? saext_pkg::ST_BAD
                                                         : saext_pkg::ST_LOOK_CHK;
         saext_pkg::ST_LOOK_CHK: state_in = status.tr_nz ? saext_pkg::ST_T_CHK
                                                        : saext_pkg::ST_FIND_RD;
         saext_pkg::ST_T_CHK:    state_in = status.t_solid ? saext_pkg::ST_HIT
                                                          : saext_pkg::ST_FIND_RD;
         saext_pkg::ST_FIND_RD:  state_in = saext_pkg::ST_FIND_CHK;
         saext_pkg::ST_FIND_CHK: begin
            if (status.tr_nz) state_in = saext_pkg::ST_QLEN;
            else if (status.p_zero)
               state_in = status.room1 ? saext_pkg::ST_ALLOC : saext_pkg::ST_REFUSE;
            else state_in = saext_pkg::ST_FIND_RD;
         end
         saext_pkg::ST_QLEN:     state_in = saext_pkg::ST_PLEN;
         saext_pkg::ST_PLEN: begin
            if (status.refuse) state_in = saext_pkg::ST_REFUSE;
            else if (status.clone_now) state_in = saext_pkg::ST_CLONE;
            else state_in = saext_pkg::ST_ALLOC;
         end
         saext_pkg::ST_ALLOC:    state_in = saext_pkg::ST_ROW_CLR;
         saext_pkg::ST_ROW_CLR:  if (status.k_last) state_in = saext_pkg::ST_W2_RD;
         saext_pkg::ST_W2_RD:    state_in = saext_pkg::ST_W2_CHK;
         saext_pkg::ST_W2_CHK:   state_in = (status.tr_nz || status.p_zero)
                                            ? saext_pkg::ST_LINK : saext_pkg::ST_W2_RD;
         saext_pkg::ST_LINK:     state_in = (!status.found || status.solid)
                                            ? saext_pkg::ST_LINK_SET : saext_pkg::ST_CLONE;
         saext_pkg::ST_LINK_SET: state_in = saext_pkg::ST_COUNT;
         saext_pkg::ST_CLONE:    state_in = saext_pkg::ST_CP_RD;
         saext_pkg::ST_CP_RD:    state_in = saext_pkg::ST_CP_WR;
         saext_pkg::ST_CP_WR:    state_in = status.k_last ? saext_pkg::ST_QLINK_RD
                                                         : saext_pkg::ST_CP_RD;
         saext_pkg::ST_QLINK_RD: state_in = saext_pkg::ST_QLINK_WR;
         saext_pkg::ST_QLINK_WR: state_in = saext_pkg::ST_W3_RD;
         saext_pkg::ST_W3_RD:    state_in = saext_pkg::ST_W3_CHK;
         saext_pkg::ST_W3_CHK:   state_in = (!status.tr_is_q || status.p_zero)
                                            ? saext_pkg::ST_FIX : saext_pkg::ST_W3_RD;
         saext_pkg::ST_FIX:      state_in = status.clone ? saext_pkg::ST_DONE
                                                        : saext_pkg::ST_CURLINK;
         saext_pkg::ST_CURLINK:  state_in = saext_pkg::ST_COUNT;
         saext_pkg::ST_COUNT:    state_in = saext_pkg::ST_DONE;
         saext_pkg::ST_BAD:      state_in = saext_pkg::ST_DONE;
         saext_pkg::ST_REFUSE:   state_in = saext_pkg::ST_DONE;
         saext_pkg::ST_HIT:      state_in = saext_pkg::ST_DONE;
         saext_pkg::ST_DONE:     if (status.slot_free) state_in = saext_pkg::ST_IDLE;
         default:                state_in = saext_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      op        = saext_pkg::OP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         saext_pkg::ST_CLEAR:    op = saext_pkg::OP_CLEAR_ROOT;
         saext_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) op = saext_pkg::OP_ACCEPT;
         end
         saext_pkg::ST_LOOK_RD:  op = saext_pkg::OP_LOOK_RD;
         saext_pkg::ST_LOOK_CHK: op = saext_pkg::OP_LOOK_CHK;
         saext_pkg::ST_T_CHK:    op = saext_pkg::OP_NONE;
         saext_pkg::ST_FIND_RD:  op = saext_pkg::OP_WALK_RD;
         saext_pkg::ST_FIND_CHK: op = saext_pkg::OP_FIND_CHK;
         saext_pkg::ST_QLEN:     op = saext_pkg::OP_QLEN;
         saext_pkg::ST_PLEN:     op = saext_pkg::OP_PLEN;
         saext_pkg::ST_ALLOC:    op = saext_pkg::OP_ALLOC;
         saext_pkg::ST_ROW_CLR:  op = saext_pkg::OP_ROW_CLR;
         saext_pkg::ST_W2_RD:    op = saext_pkg::OP_WALK_RD;
         saext_pkg::ST_W2_CHK:   op = saext_pkg::OP_W2_CHK;
         saext_pkg::ST_LINK:     op = saext_pkg::OP_NONE;
         saext_pkg::ST_LINK_SET: op = saext_pkg::OP_LINK_SET;
         saext_pkg::ST_CLONE:    op = saext_pkg::OP_CLONE;
         saext_pkg::ST_CP_RD:    op = saext_pkg::OP_CP_RD;
         saext_pkg::ST_CP_WR:    op = saext_pkg::OP_CP_WR;
         saext_pkg::ST_QLINK_RD: op = saext_pkg::OP_QLINK_RD;
         saext_pkg::ST_QLINK_WR: op = saext_pkg::OP_QLINK_WR;
         saext_pkg::ST_W3_RD:    op = saext_pkg::OP_WALK_RD;
         saext_pkg::ST_W3_CHK:   op = saext_pkg::OP_W3_CHK;
         saext_pkg::ST_FIX:      op = saext_pkg::OP_FIX;
         saext_pkg::ST_CURLINK:  op = saext_pkg::OP_CURLINK;
         saext_pkg::ST_COUNT:    op = saext_pkg::OP_COUNT;
         saext_pkg::ST_BAD:      op = saext_pkg::OP_RES_BAD;
         saext_pkg::ST_REFUSE:   op = saext_pkg::OP_RES_FULL;
         saext_pkg::ST_HIT:      op = saext_pkg::OP_RES_T;
         saext_pkg::ST_DONE:     if (status.slot_free) op = saext_pkg::OP_EMIT;
         default:                op = saext_pkg::OP_NONE;
      endcase
   end

`ifndef SYNTHESIS
   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == saext_pkg::ST_IDLE && op != saext_pkg::OP_EMIT)
      else $error("ready outside idle");
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == saext_pkg::ST_LOOK_RD)
      else $error("accepted item not started");
   a_emit_to_idle: assert property (@(posedge clock) disable iff (reset)
      op == saext_pkg::OP_EMIT |=> state_ff == saext_pkg::ST_IDLE)
      else $error("emit did not return to idle");
`endif

endmodule

FILE: rtl/saext_dp.sv
// Datapath: transition, link and length memories, walk registers and result register.
module saext_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  saext_pkg::op_type     op,
   output saext_pkg::status_type status,
   saext_req_if.sink             req_ch,
   saext_rsp_if.source           rsp_ch
);

   logic [saext_pkg::STATE_W-1:0] tr_mem   [saext_pkg::TR_DEPTH];
   logic [saext_pkg::STATE_W-1:0] link_mem [saext_pkg::STATE_COUNT];
   logic [saext_pkg::LEN_W-1:0]   len_mem  [saext_pkg::STATE_COUNT];

   logic [saext_pkg::SYM_W-1:0]   c_ff;
   logic [saext_pkg::STATE_W-1:0] lst_ff, p_ff, pf_ff, q_ff, t_ff, cur_ff, nq_ff;
   logic [saext_pkg::LEN_W-1:0]   len_lst_ff, len_q_ff, len_p_ff, add_ff;
   logic                          found_ff, solid_ff, clone_ff;
   logic [saext_pkg::K_W-1:0]     k_ff;
   logic [saext_pkg::USED_W-1:0]  used_ff;
   logic [saext_pkg::COUNT_W-1:0] count_ff;
   logic [saext_pkg::STATE_W-1:0] res_state_ff;
   logic                          res_full_ff;
   logic                          rsp_valid_ff;
   logic [saext_pkg::STATE_W-1:0] rsp_state_ff;
   logic [saext_pkg::COUNT_W-1:0] rsp_count_ff;
   logic                          rsp_full_ff;

   logic [saext_pkg::STATE_W-1:0] tr_rd_ff, link_rd_ff;
   logic [saext_pkg::LEN_W-1:0]   len_rd_ff;
   logic                          len_zero_ff;

   logic [saext_pkg::TR_AW-1:0]   tr_ra, tr_wa;
   logic [saext_pkg::STATE_W-1:0] tr_wd, link_ra, link_wa, link_wd, len_ra, len_wa;
   logic [saext_pkg::LEN_W-1:0]   len_wd;
   logic                          tr_we, link_we, len_we;

   logic [saext_pkg::LEN_W-1:0]   len_val, len_cur;
   logic [saext_pkg::USED_W-1:0]  next_id;
   logic [saext_pkg::COUNT_W:0]   count_sum;
   logic                          k_last, room1, room2, solid_now, clone_now;

   assign len_val   = len_zero_ff ? '0 : len_rd_ff;
   assign len_cur   = len_lst_ff + saext_pkg::LEN_W'(1);
   assign next_id   = used_ff + saext_pkg::USED_W'(1);
   assign count_sum = {1'b0, count_ff} + (saext_pkg::COUNT_W+1)'(add_ff);
   assign k_last    = k_ff == saext_pkg::K_W'(saext_pkg::ALPHABET_SIZE - 1);
   assign room1     = used_ff < saext_pkg::USED_W'(saext_pkg::STATE_COUNT - 1);
   assign room2     = ({1'b0, used_ff} + (saext_pkg::USED_W+1)'(2))
                      <= (saext_pkg::USED_W+1)'(saext_pkg::STATE_COUNT - 1);
   assign solid_now = len_q_ff == len_val + saext_pkg::LEN_W'(1);
   assign clone_now = pf_ff == lst_ff;

   always_comb begin
      status.sym_bad   = c_ff >= saext_pkg::SYM_W'(saext_pkg::ALPHABET_SIZE);
      status.tr_nz     = tr_rd_ff != '0;
      status.tr_is_q   = tr_rd_ff == q_ff;
      status.t_solid   = len_val == len_cur;
      status.p_zero    = p_ff == '0;
      status.room1     = room1;
      status.refuse    = (solid_now || clone_now) ? !room1 : !room2;
      status.clone_now = clone_now;
      status.found     = found_ff;
      status.solid     = solid_ff;
      status.clone     = clone_ff;
      status.k_last    = k_last;
      status.slot_free = !rsp_valid_ff || rsp_ch.ready;
   end

   always_comb begin
      tr_ra   = '0;
      link_ra = '0;
      len_ra  = '0;
      tr_we   = 1'b0;
      tr_wa   = '0;
      tr_wd   = '0;
      link_we = 1'b0;
      link_wa = '0;
      link_wd = '0;
      len_we  = 1'b0;
      len_wa  = '0;
      len_wd  = '0;
      case (op)
         saext_pkg::OP_CLEAR_ROOT: begin
            tr_we = 1'b1;
            tr_wa = saext_pkg::tr_addr('0, saext_pkg::SYM_W'(k_ff));
         end
         saext_pkg::OP_LOOK_RD: begin
            tr_ra  = saext_pkg::tr_addr(lst_ff, c_ff);
            len_ra = lst_ff;
         end
         saext_pkg::OP_LOOK_CHK, saext_pkg::OP_FIND_CHK: len_ra = tr_rd_ff;
         saext_pkg::OP_WALK_RD: begin
            tr_ra   = saext_pkg::tr_addr(p_ff, c_ff);
            link_ra = p_ff;
         end
         saext_pkg::OP_QLEN: len_ra = pf_ff;
         saext_pkg::OP_ALLOC: begin
            len_we = 1'b1;
            len_wa = next_id[saext_pkg::STATE_W-1:0];
            len_wd = len_cur;
         end
         saext_pkg::OP_ROW_CLR: begin
            tr_we = 1'b1;
            tr_wa = saext_pkg::tr_addr(cur_ff, saext_pkg::SYM_W'(k_ff));
         end
         saext_pkg::OP_W2_CHK: begin
            tr_we = tr_rd_ff == '0;
            tr_wa = saext_pkg::tr_addr(p_ff, c_ff);
            tr_wd = cur_ff;
         end
         saext_pkg::OP_LINK_SET: begin
            link_we = 1'b1;
            link_wa = cur_ff;
            link_wd = found_ff ? q_ff : '0;
         end
         saext_pkg::OP_CLONE: begin
            len_we = 1'b1;
            len_wa = next_id[saext_pkg::STATE_W-1:0];
            len_wd = len_p_ff + saext_pkg::LEN_W'(1);
         end
         saext_pkg::OP_CP_RD: tr_ra = saext_pkg::tr_addr(q_ff, saext_pkg::SYM_W'(k_ff));
         saext_pkg::OP_CP_WR: begin
            tr_we = 1'b1;
            tr_wa = saext_pkg::tr_addr(nq_ff, saext_pkg::SYM_W'(k_ff));
            tr_wd = tr_rd_ff;
         end
         saext_pkg::OP_QLINK_RD: link_ra = q_ff;
         saext_pkg::OP_QLINK_WR: begin
            link_we = 1'b1;
            link_wa = nq_ff;
            link_wd = link_rd_ff;
         end
         saext_pkg::OP_W3_CHK: begin
            tr_we = tr_rd_ff == q_ff;
            tr_wa = saext_pkg::tr_addr(p_ff, c_ff);
            tr_wd = nq_ff;
         end
         saext_pkg::OP_FIX: begin
            link_we = 1'b1;
            link_wa = q_ff;
            link_wd = nq_ff;
         end
         saext_pkg::OP_CURLINK: begin
            link_we = 1'b1;
            link_wa = cur_ff;
            link_wd = nq_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (tr_we) tr_mem[tr_wa] <= tr_wd;
      tr_rd_ff <= tr_mem[tr_ra];
   end

   always_ff @(posedge clock) begin
      if (link_we) link_mem[link_wa] <= link_wd;
      link_rd_ff <= link_mem[link_ra];
   end

   always_ff @(posedge clock) begin
      if (len_we) len_mem[len_wa] <= len_wd;
      len_rd_ff   <= len_mem[len_ra];
      len_zero_ff <= len_ra == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= '0;
         used_ff      <= '0;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         solid_ff     <= 1'b0;
         clone_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (op)
            saext_pkg::OP_ACCEPT: begin
               c_ff     <= req_ch.symbol;
               lst_ff   <= ({1'b0, req_ch.from_state} > used_ff) ? '0 : req_ch.from_state;
               found_ff <= 1'b0;
               solid_ff <= 1'b0;
               clone_ff <= 1'b0;
            end
            saext_pkg::OP_LOOK_RD: p_ff <= lst_ff;
            saext_pkg::OP_LOOK_CHK: begin
               t_ff       <= tr_rd_ff;
               len_lst_ff <= len_val;
            end
            saext_pkg::OP_FIND_CHK: begin
               if (tr_rd_ff != '0) begin
                  q_ff     <= tr_rd_ff;
                  pf_ff    <= p_ff;
                  found_ff <= 1'b1;
               end else begin
                  p_ff <= link_rd_ff;
               end
            end
            saext_pkg::OP_QLEN: len_q_ff <= len_val;
            saext_pkg::OP_PLEN: begin
               len_p_ff <= len_val;
               solid_ff <= solid_now;
               clone_ff <= clone_now && !solid_now;
            end
            saext_pkg::OP_ALLOC: begin
               cur_ff  <= next_id[saext_pkg::STATE_W-1:0];
               used_ff <= next_id;
               k_ff    <= '0;
               p_ff    <= lst_ff;
            end
            saext_pkg::OP_CLEAR_ROOT, saext_pkg::OP_ROW_CLR, saext_pkg::OP_CP_WR:
               k_ff <= k_last ? '0 : k_ff + saext_pkg::K_W'(1);
            saext_pkg::OP_W2_CHK:
               if (tr_rd_ff == '0 && p_ff != '0) p_ff <= link_rd_ff;
            saext_pkg::OP_LINK_SET:
               add_ff <= len_cur - (found_ff ? len_q_ff : '0);
            saext_pkg::OP_CLONE: begin
               nq_ff   <= next_id[saext_pkg::STATE_W-1:0];
               used_ff <= next_id;
               k_ff    <= '0;
               p_ff    <= pf_ff;
            end
            saext_pkg::OP_W3_CHK:
               if (tr_rd_ff == q_ff && p_ff != '0) p_ff <= link_rd_ff;
            saext_pkg::OP_FIX: begin
               res_state_ff <= nq_ff;
               res_full_ff  <= 1'b0;
            end
            saext_pkg::OP_CURLINK:
               add_ff <= len_cur - (len_p_ff + saext_pkg::LEN_W'(1));
            saext_pkg::OP_COUNT: begin
               count_ff     <= (count_sum > {1'b0, saext_pkg::COUNT_MAX})
                               ? saext_pkg::COUNT_MAX : count_sum[saext_pkg::COUNT_W-1:0];
               res_state_ff <= cur_ff;
               res_full_ff  <= 1'b0;
            end
            saext_pkg::OP_RES_BAD: begin
               res_state_ff <= '0;
               res_full_ff  <= 1'b0;
            end
            saext_pkg::OP_RES_FULL: begin
               res_state_ff <= '0;
               res_full_ff  <= 1'b1;
            end
            saext_pkg::OP_RES_T: begin
               res_state_ff <= t_ff;
               res_full_ff  <= 1'b0;
            end
            default: ;
         endcase
         if (op == saext_pkg::OP_EMIT) begin
            rsp_valid_ff <= 1'b1;
            rsp_state_ff <= res_state_ff;
            rsp_count_ff <= count_ff;
            rsp_full_ff  <= res_full_ff;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.next_state     = rsp_state_ff;
   assign rsp_ch.distinct_total = rsp_count_ff;
   assign rsp_ch.table_full     = rsp_full_ff;

`ifndef SYNTHESIS
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= saext_pkg::USED_W'(saext_pkg::STATE_COUNT - 1))
      else $error("state table overrun");
   a_used_grows: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> used_ff >= $past(used_ff))
      else $error("state count went down");
   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> count_ff >= $past(count_ff))
      else $error("substring count went down");
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      op == saext_pkg::OP_EMIT |=> rsp_valid_ff && rsp_count_ff == $past(count_ff))
      else $error("emitted item not shown");
`endif

endmodule

FILE: rtl/suffix_automaton_extend.sv
// Generalized suffix automaton extender: top level joining sequencer and datapath.
// Each item takes a symbol and a state to extend from and returns one item with
// the state reached, the running distinct-substring count and a table-full flag.
// Items are handled one at a time. An item that hits an existing solid
// transition, or one with a symbol outside the alphabet, skips the walks.
// Otherwise a from state that already has a transition on the symbol is
// checked first, then the search walk runs; when it finds a target, the
// lengths of the target and its source are read. A new state then has its
// transition row cleared before the redirect walk (both walks start at the
// from state). A clone copies the target's transition row and link, then
// retargets transitions on a walk; an item that only makes a clone skips the
// row clear and the redirect walk. A refused item ends after its search walk.
// After reset the root row is cleared before the first item is taken. A
// finished item waits in an output register, so the next item is accepted
// while it is pending.
module suffix_automaton_extend (
   input  logic        clock,
   input  logic        reset,
   saext_req_if.sink   req_ch,
   saext_rsp_if.source rsp_ch
);

   saext_pkg::op_type     op;
   saext_pkg::status_type status;
   logic                  req_ready;

   assign req_ch.ready = req_ready;

   saext_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .op        (op)
   );

   saext_dp u_dp (
      .clock  (clock),
      .reset  (reset),
      .op     (op),
      .status (status),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule
